// File: sv/cda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cda_pkg;
  localparam int unsigned DotW   = 44;
  localparam int unsigned NormW  = 43;
  localparam int unsigned ValW   = 16;
  localparam int unsigned DistW  = 18;
  localparam int unsigned ProdW  = 2 * NormW;      // qn*rn
  localparam int unsigned TgtW   = 2 * DotW + 32;  // dot^2 << 32
  localparam int unsigned KW     = 17;             // k in 0..65536
  localparam int unsigned CmpW   = ProdW + 2 * KW;
  localparam logic [KW-1:0] OneQ16 = KW'(65536);

  typedef struct packed {
    logic start;    // latch sums, begin distance search
  } cda_cmd_t;

  typedef struct packed {
    logic done;     // distance ready
  } cda_sts_t;
endpackage
`default_nettype wire

// File: sv/cda_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cda_in_if;
  logic valid;
  logic ready;
  logic signed [cda_pkg::ValW-1:0] query_value;
  logic signed [cda_pkg::ValW-1:0] reference_value;
  logic last_element;
  modport source (output valid, query_value, reference_value, last_element, input ready);
  modport sink   (input valid, query_value, reference_value, last_element, output ready);
endinterface

interface cda_out_if;
  logic valid;
  logic ready;
  logic [cda_pkg::DistW-1:0] distance;
  logic zero_norm;
  modport source (output valid, distance, zero_norm, input ready);
  modport sink   (input valid, distance, zero_norm, output ready);
endinterface
`default_nettype wire

// File: sv/cda_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Accumulators plus a shift-and-add search for k, one bit of k per sum step and compare step.
// y tracks k*k*prod, w tracks k*prod << (bit+1), pp tracks prod << 2*bit, so the
// square of a candidate is y + w + pp with no multiplier in the loop.
module cda_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               acc_en_i,
  input  wire logic                               acc_clr_i,
  input  wire logic signed [cda_pkg::ValW-1:0]    q_i,
  input  wire logic signed [cda_pkg::ValW-1:0]    r_i,
  input  wire cda_pkg::cda_cmd_t                  cmd_i,
  output cda_pkg::cda_sts_t                       sts_o,
  output logic                                    norm_zero_o,
  output logic [cda_pkg::DistW-1:0]               dist_o
);
  localparam int unsigned DW = cda_pkg::DotW;
  localparam int unsigned NW = cda_pkg::NormW;
  localparam int unsigned KW = cda_pkg::KW;
  localparam int unsigned PW = cda_pkg::ProdW;
  localparam int unsigned TW = cda_pkg::TgtW;
  localparam int unsigned CW = cda_pkg::CmpW;
  localparam int unsigned DstW = cda_pkg::DistW;

  // phases: qn*rn in four partial products, dot^2 in three, then per bit
  // a sum step and a compare step
  localparam logic [3:0] PhIdle = 4'd0, PhP0 = 4'd1, PhP1 = 4'd2, PhP2 = 4'd3;
  localparam logic [3:0] PhP3 = 4'd4, PhT0 = 4'd5, PhT1 = 4'd6, PhT2 = 4'd7;
  localparam logic [3:0] PhSum = 4'd8, PhCmp = 4'd9, PhDone = 4'd10;

  logic signed [DW-1:0] dot_q, dot_d, dot_a;
  logic [NW-1:0] qn_q, qn_d, qn_a, rn_q, rn_d, rn_a;
  logic signed [31:0] p_w, qq_w, rr_w;
  logic signed [DW:0] dot_sum_w;
  logic [NW:0] qn_sum_w, rn_sum_w;

  logic [3:0] ph_q, ph_d;
  logic [4:0] bit_q, bit_d;
  logic neg_q, neg_d;
  logic [DW-1:0] mag_q, mag_d;
  logic [NW-1:0] a_q, a_d, b_q, b_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [TW-1:0] tgt_q, tgt_d;
  logic [KW-1:0] k_q, k_d, cand_w, kinc_w;
  logic [CW-1:0] y_q, y_d, w_q, w_d, pp_q, pp_d, t_q, t_d;
  logic [63:0] pm_w;
  logic [31:0] ma_w, mb_w;
  logic fit_w, exact_w;

  assign p_w  = q_i * r_i;
  assign qq_w = q_i * q_i;
  assign rr_w = r_i * r_i;
  assign dot_sum_w = (DW+1)'(dot_q) + (DW+1)'(p_w);
  assign qn_sum_w  = (NW+1)'(qn_q) + (NW+1)'(qq_w);
  assign rn_sum_w  = (NW+1)'(rn_q) + (NW+1)'(rr_w);

  // sums including the current pair, before any clear
  always_comb begin
    dot_a = dot_q;
    qn_a  = qn_q;
    rn_a  = rn_q;
    if (acc_en_i) begin
      if (dot_sum_w[DW] != dot_sum_w[DW-1]) begin
        dot_a = dot_sum_w[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        dot_a = dot_sum_w[DW-1:0];
      end
      qn_a = qn_sum_w[NW] ? {NW{1'b1}} : qn_sum_w[NW-1:0];
      rn_a = rn_sum_w[NW] ? {NW{1'b1}} : rn_sum_w[NW-1:0];
    end
    dot_d = acc_clr_i ? '0 : dot_a;
    qn_d  = acc_clr_i ? '0 : qn_a;
    rn_d  = acc_clr_i ? '0 : rn_a;
  end

  assign norm_zero_o = (qn_a == '0) || (rn_a == '0);

  assign cand_w = k_q | (KW'(1) << bit_q);
  assign pm_w = 64'(ma_w) * 64'(mb_w);
  assign fit_w = (cand_w <= cda_pkg::OneQ16) && (t_q <= CW'(tgt_q));
  assign exact_w = (y_q == CW'(tgt_q));
  assign kinc_w = exact_w ? k_q : k_q + KW'(1);
  assign sts_o.done = (ph_q == PhDone);

  always_comb begin
    ma_w = '0;
    mb_w = '0;
    unique case (ph_q)
      PhP0: begin ma_w = a_q[31:0]; mb_w = b_q[31:0]; end
      PhP1: begin ma_w = a_q[31:0]; mb_w = 32'(b_q[NW-1:32]); end
      PhP2: begin ma_w = 32'(a_q[NW-1:32]); mb_w = b_q[31:0]; end
      PhP3: begin ma_w = 32'(a_q[NW-1:32]); mb_w = 32'(b_q[NW-1:32]); end
      PhT0: begin ma_w = mag_q[31:0]; mb_w = mag_q[31:0]; end
      PhT1: begin ma_w = mag_q[31:0]; mb_w = 32'(mag_q[DW-1:32]); end
      PhT2: begin ma_w = 32'(mag_q[DW-1:32]); mb_w = 32'(mag_q[DW-1:32]); end
      default: ;
    endcase
  end

  always_comb begin
    ph_d = ph_q; bit_d = bit_q; neg_d = neg_q; mag_d = mag_q; a_d = a_q; b_d = b_q;
    prod_d = prod_q; tgt_d = tgt_q; k_d = k_q; y_d = y_q; w_d = w_q; pp_d = pp_q;
    t_d = t_q;
    if (cmd_i.start) begin
      ph_d = PhP0;
      neg_d = dot_a[DW-1];
      mag_d = dot_a[DW-1] ? DW'(-dot_a) : DW'(dot_a);
      a_d = qn_a;
      b_d = rn_a;
    end else begin
      unique case (ph_q)
        PhIdle: ;
        PhP0: begin prod_d = PW'(pm_w); ph_d = PhP1; end
        PhP1: begin prod_d = prod_q + (PW'(pm_w) << 32); ph_d = PhP2; end
        PhP2: begin prod_d = prod_q + (PW'(pm_w) << 32); ph_d = PhP3; end
        PhP3: begin prod_d = prod_q + (PW'(pm_w) << 64); ph_d = PhT0; end
        PhT0: begin tgt_d = TW'(pm_w) << 32; ph_d = PhT1; end
        PhT1: begin tgt_d = tgt_q + (TW'({pm_w, 1'b0}) << 64); ph_d = PhT2; end
        PhT2: begin
          tgt_d = tgt_q + (TW'(pm_w) << 96);
          k_d = '0;
          y_d = '0;
          w_d = '0;
          pp_d = CW'(prod_q) << (2 * (KW - 1));
          bit_d = 5'(KW - 1);
          ph_d = PhSum;
        end
        PhSum: begin t_d = y_q + w_q + pp_q; ph_d = PhCmp; end
        PhCmp: begin
          if (fit_w) begin
            k_d = cand_w;
            y_d = t_q;
            w_d = (w_q >> 1) + pp_q;
          end else begin
            w_d = w_q >> 1;
          end
          pp_d = pp_q >> 2;
          if (bit_q == '0) ph_d = PhDone;
          else begin bit_d = bit_q - 5'd1; ph_d = PhSum; end
        end
        PhDone: ph_d = PhIdle;
        default: ph_d = PhIdle;
      endcase
    end
  end

  always_comb begin
    if (neg_q) dist_o = DstW'(cda_pkg::OneQ16) + DstW'(k_q);
    else if (kinc_w >= cda_pkg::OneQ16) dist_o = '0;
    else dist_o = DstW'(cda_pkg::OneQ16 - kinc_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      qn_q  <= '0;
      rn_q  <= '0;
      ph_q  <= PhIdle;
    end else begin
      dot_q <= dot_d;
      qn_q  <= qn_d;
      rn_q  <= rn_d;
      ph_q  <= ph_d;
    end
  end
  always_ff @(posedge clk_i) begin
    bit_q <= bit_d; neg_q <= neg_d; mag_q <= mag_d; a_q <= a_d; b_q <= b_d;
    prod_q <= prod_d; tgt_q <= tgt_d; k_q <= k_d; y_q <= y_d; w_q <= w_d;
    pp_q <= pp_d; t_q <= t_d;
  end
endmodule
`default_nettype wire

// File: sv/cda_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cda_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  output logic                    acc_en_o,
  output logic                    acc_clr_o,
  input  wire logic               norm_zero_i,
  output cda_pkg::cda_cmd_t       cmd_o,
  input  wire cda_pkg::cda_sts_t  sts_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    out_zero_o,
  input  wire logic [cda_pkg::DistW-1:0] dist_i,
  output logic [cda_pkg::DistW-1:0] out_dist_o
);
  localparam logic [1:0] StAcc = 2'd0, StCalc = 2'd1, StOut = 2'd2;
  logic [1:0] st_q, st_d;
  logic zero_q, zero_d;
  logic [cda_pkg::DistW-1:0] dist_q, dist_d;
  logic fire_w;

  assign in_ready_o = (st_q == StAcc);
  assign fire_w = in_valid_i && in_ready_o;
  assign acc_en_o = fire_w;
  assign acc_clr_o = 1'b0;
  assign out_valid_o = (st_q == StOut);
  assign out_zero_o = zero_q;
  assign out_dist_o = dist_q;

  always_comb begin
    st_d = st_q; zero_d = zero_q; dist_d = dist_q;
    cmd_o.start = 1'b0;
    unique case (st_q)
      StAcc: if (fire_w && in_last_i) begin
        if (norm_zero_i) begin
          zero_d = 1'b1; dist_d = '0; st_d = StOut;
        end else begin
          cmd_o.start = 1'b1; zero_d = 1'b0; st_d = StCalc;
        end
      end
      StCalc: if (sts_i.done) begin dist_d = dist_i; st_d = StOut; end
      StOut: if (out_ready_i) st_d = StAcc;
      default: st_d = StAcc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StAcc;
    else st_q <= st_d;
  end
  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    dist_q <= dist_d;
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StAcc) |-> !acc_en_o) else $error("accepted while busy");
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.done |-> (st_q == StCalc)) else $error("done outside calc");
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_q) |-> (dist_q == '0)) else $error("zero norm dist");
endmodule
`default_nettype wire

// File: sv/cosine_distance_accumulator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  fields
// in_if    in   query_value, reference_value, last_element
// out_if   out  distance, zero_norm
// One pair per cycle is summed while no result is pending. A last pair with
// nonzero norms starts the distance search: 7 partial products of 32x32 for
// qn*rn and dot^2, then a sum step and a compare step for each of the 17 bits
// of k; no input is taken until the result is transferred. Zero norm: valid next cycle.
// Result holds until transferred. Reset clears sums and control.
module cosine_distance_accumulator_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cda_in_if.sink    in_if,
  cda_out_if.source out_if
);
  cda_pkg::cda_cmd_t cmd_w;
  cda_pkg::cda_sts_t sts_w;
  logic en_w, clr_w, nz_w, zero_w;
  logic [cda_pkg::DistW-1:0] dist_w, odist_w;

  cda_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_last_i(in_if.last_element), .in_ready_o(in_if.ready),
    .acc_en_o(en_w), .acc_clr_o(clr_w), .norm_zero_i(nz_w),
    .cmd_o(cmd_w), .sts_i(sts_w),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_zero_o(zero_w), .dist_i(dist_w), .out_dist_o(odist_w)
  );

  cda_datapath u_dp (
    .clk_i, .rst_ni,
    .acc_en_i(en_w), .acc_clr_i(clr_w || (en_w && in_if.last_element)),
    .q_i(in_if.query_value), .r_i(in_if.reference_value),
    .cmd_i(cmd_w), .sts_o(sts_w), .norm_zero_o(nz_w), .dist_o(dist_w)
  );

  assign out_if.distance = odist_w;
  assign out_if.zero_norm = zero_w;
endmodule
`default_nettype wire

// File: verif/tb_cosine_distance_accumulator_unit.sv
`timescale 1ns / 1ps
module tb_cosine_distance_accumulator_unit;
  localparam int     ValW       = cda_pkg::ValW;
  localparam int     DistW      = cda_pkg::DistW;
  localparam longint SumDotMax  = 64'sh7FF_FFFF_FFFF;
  localparam longint SumDotMin  = -64'sh800_0000_0000;
  localparam longint SumNormMax = 64'sh7FF_FFFF_FFFF;
  localparam int     IdleLimit  = 20000;

  typedef struct {
    logic [DistW-1:0] distance;
    logic             zero_norm;
  } dist_res_t;

  typedef struct {
    int   q;
    int   r;
    bit   last;
    bit   fixed;
    int   exp_dist;
    bit   zero;
  } vec_row_t;

  logic clk_i;
  logic rst_ni;

  cda_in_if  in_if ();
  cda_out_if out_if ();

  cosine_distance_accumulator_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  longint    dot_acc;
  longint    qnorm_acc;
  longint    rnorm_acc;
  dist_res_t pending_dist[$];
  int        errors;
  int        idle_cycles;
  int        gap_pct;
  int        stall_pct;
  vec_row_t  rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Exact floor(65536 - 65536*dot/sqrt(qn*rn)) via integer search on k.
  function automatic logic [DistW-1:0] cosine_dist(input longint dot, input longint qn,
                                                   input longint rn);
    logic [159:0] prod;
    logic [159:0] target;
    logic [159:0] mag;
    logic [159:0] kk;
    longint       lo;
    longint       hi;
    longint       mid;
    bit           neg;
    neg = dot < 0;
    mag = neg ? 160'(-dot) : 160'(dot);
    prod = 160'(qn) * 160'(rn);
    target = (mag * mag) << 32;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      kk = 160'(mid * mid);
      if (prod * kk <= target) lo = mid;
      else hi = mid - 1;
    end
    if (neg) return DistW'(65536 + lo);
    kk = 160'(lo * lo);
    if (prod * kk != target) lo++;
    if (lo >= 65536) return '0;
    return DistW'(65536 - lo);
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Update the accumulators for one accepted pair; queue a result on last.
  task automatic accumulate(input logic signed [ValW-1:0] q, input logic signed [ValW-1:0] r,
                            input bit last, input bit fixed, input int fd, input bit fz);
    longint    qs;
    longint    rs;
    dist_res_t res;
    qs = q;
    rs = r;
    dot_acc   = sat(dot_acc + qs * rs, SumDotMin, SumDotMax);
    qnorm_acc = sat(qnorm_acc + qs * qs, 0, SumNormMax);
    rnorm_acc = sat(rnorm_acc + rs * rs, 0, SumNormMax);
    if (!last) return;
    if (qnorm_acc == 0 || rnorm_acc == 0) begin
      res.distance  = '0;
      res.zero_norm = 1'b1;
    end else begin
      res.distance  = cosine_dist(dot_acc, qnorm_acc, rnorm_acc);
      res.zero_norm = 1'b0;
    end
    if (fixed) begin
      if (res.distance !== DistW'(fd) || res.zero_norm !== fz)
        report_mismatch("predictor vs table", res.distance, fd);
      res.distance  = DistW'(fd);
      res.zero_norm = fz;
    end
    pending_dist.push_back(res);
    dot_acc   = 0;
    qnorm_acc = 0;
    rnorm_acc = 0;
  endtask

  task automatic send_pair(input logic signed [ValW-1:0] q, input logic signed [ValW-1:0] r,
                           input bit last, input bit fixed = 0, input int fd = 0,
                           input bit fz = 0);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.query_value     <= q;
    in_if.reference_value <= r;
    in_if.last_element    <= last;
    do @(posedge clk_i); while (!in_if.ready);
    accumulate(q, r, last, fixed, fd, fz);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [ValW-1:0] rand_val();
    case ($urandom_range(5))
      0:       return ValW'($urandom_range(7)) - 16'sd3;
      1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      2:       return ValW'($urandom_range(511)) - 16'sd256;
      default: return ValW'($urandom);
    endcase
  endfunction

  task automatic send_vector(input int len);
    logic signed [ValW-1:0] q;
    logic signed [ValW-1:0] r;
    int                     mode;
    mode = $urandom_range(5);
    for (int i = 0; i < len; i++) begin
      q = rand_val();
      case (mode)
        0:       r = q;                          // parallel
        1:       r = -q;                         // antiparallel
        2:       r = q >>> 1;
        3:       r = (i == 0) ? 16'sd0 : rand_val();
        default: r = rand_val();
      endcase
      send_pair(q, r, i == len - 1);
    end
  endtask

  // Receiver, checker and idle-cycle watchdog.
  always @(posedge clk_i) begin
    dist_res_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_if.valid && out_if.ready) begin
        if (pending_dist.size() == 0) begin
          report_mismatch("unexpected result, distance", out_if.distance, -1);
        end else begin
          want = pending_dist.pop_front();
          if (out_if.distance !== want.distance)
            report_mismatch("distance", out_if.distance, want.distance);
          if (out_if.zero_norm !== want.zero_norm)
            report_mismatch("zero_norm", out_if.zero_norm, want.zero_norm);
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    in_if.valid           = 1'b0;
    in_if.query_value     = '0;
    in_if.reference_value = '0;
    in_if.last_element    = 1'b0;
    out_if.ready          = 1'b0;
    rst_ni      = 1'b0;
    dot_acc     = 0;
    qnorm_acc   = 0;
    rnorm_acc   = 0;
    errors      = 0;
    idle_cycles = 0;
    gap_pct     = 0;
    stall_pct   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("watchdog: no transfer for %0d cycles", IdleLimit);
    $display("cosine_distance_accumulator_unit: mismatch");
    $finish;
  end

  initial begin
    int pct[4][2];
    int n_sent;
    int len;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed vectors: fixed expectations only where obvious
    rows.push_back('{0, 0, 1, 1, 0, 1});                    // empty norms
    rows.push_back('{256, 256, 1, 1, 0, 0});                // identical
    rows.push_back('{256, -256, 1, 1, 131072, 0});          // opposite
    rows.push_back('{0, 5, 1, 1, 0, 1});                    // query norm zero
    rows.push_back('{-7, 0, 1, 1, 0, 1});                   // reference norm zero
    rows.push_back('{-32768, -32768, 1, 1, 0, 0});
    rows.push_back('{32767, -32768, 1, 1, 131072, 0});
    rows.push_back('{32767, 32767, 1, 1, 0, 0});
    rows.push_back('{256, 0, 0, 0, 0, 0});                  // orthogonal pair
    rows.push_back('{0, 256, 1, 1, 65536, 0});
    rows.push_back('{100, 300, 0, 0, 0, 0});
    rows.push_back('{-200, 50, 0, 0, 0, 0});
    rows.push_back('{7, -9, 1, 0, 0, 0});
    rows.push_back('{1, 1, 0, 0, 0, 0});
    rows.push_back('{1, 2, 1, 0, 0, 0});
    rows.push_back('{-32768, 32767, 0, 0, 0, 0});
    rows.push_back('{12345, -23456, 1, 0, 0, 0});
    rows.push_back('{3, 4, 1, 0, 0, 0});
    foreach (rows[i])
      send_pair(ValW'(rows[i].q), ValW'(rows[i].r), rows[i].last, rows[i].fixed,
                rows[i].exp_dist, rows[i].zero);
    drain_results();

    pct = '{'{0, 0}, '{85, 0}, '{0, 85}, '{36, 36}};
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = pct[ph][0];
      stall_pct = pct[ph][1];
      n_sent    = 0;
      while (n_sent < 480) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
        // a stretch without idling now and then
        if ($urandom_range(7) == 0) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else begin
          gap_pct   = pct[ph][0];
          stall_pct = pct[ph][1];
        end
        send_vector(len);
        n_sent += len;
      end
      drain_results();
    end

    stall_pct = 0;
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_dist.size() == 0) begin
      $display("cosine_distance_accumulator_unit: match");
    end else begin
      $display("cosine_distance_accumulator_unit: mismatch");
    end
    $finish;
  end
endmodule
